>>> hw/rtl/tfs_pkg.sv
// ----------------------------------------------------------------------------
// Texture filter sampler package
// Shared constants, request codes and the command and status types that join
// the sampler controller to its datapath.
// ----------------------------------------------------------------------------
package tfs_pkg;

   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int COORD_W     = 19;
   localparam int BLEND_W     = 17;
   localparam int RGBA_W      = 32;
   localparam int POS_W       = 6;

   localparam logic [1:0] REQ_WRITE     = 2'd0;
   localparam logic [1:0] REQ_BILINEAR  = 2'd1;
   localparam logic [1:0] REQ_TRILINEAR = 2'd2;
   localparam logic [1:0] REQ_ANISO     = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEXT_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEXT_HEIGHT = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_WRITE,
      OP_SQUARE,
      OP_COUNT,
      OP_OFFSET,
      OP_DIV_TAP,
      OP_TAP_POS,
      OP_CENTER,
      OP_XF,
      OP_IDX,
      OP_WGT,
      OP_TAP_END,
      OP_BLEND,
      OP_DIV_AVG,
      OP_AVG_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       acc_en;
      logic [1:0] acc_sel;
      logic       lvl_force;
      logic       lvl_val;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_tap;
   } dp_status_type;

endpackage

>>> hw/rtl/tfs_div.sv
// ----------------------------------------------------------------------------
// Texture filter sampler serial divider
// Restoring division, one quotient bit per cycle, over several lanes that
// share one divisor.
// ----------------------------------------------------------------------------
module tfs_div #(
   parameter int LANES = 4,
   parameter int DW    = 25,
   parameter int VW    = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [LANES-1:0][DW-1:0]   dividend,
   input  logic [VW-1:0]              divisor,
   output logic [LANES-1:0][DW-1:0]   quotient,
   output logic [LANES-1:0]           rem_nonzero,
   output logic                       done
);

   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]   quo_ff [LANES];
   logic [DW-1:0]   quo_in [LANES];
   logic [VW-1:0]   rem_ff [LANES];
   logic [VW-1:0]   rem_in [LANES];
   logic [VW-1:0]   div_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   always_comb begin
      logic [VW:0] shifted;
      logic [VW:0] diff;
      for (int l = 0; l < LANES; l++) begin
         shifted = {rem_ff[l], quo_ff[l][DW-1]};
         diff    = shifted - {1'b0, div_ff};
         if (diff[VW]) begin
            rem_in[l] = shifted[VW-1:0];
            quo_in[l] = {quo_ff[l][DW-2:0], 1'b0};
         end else begin
            rem_in[l] = diff[VW-1:0];
            quo_in[l] = {quo_ff[l][DW-2:0], 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         for (int l = 0; l < LANES; l++) begin
            quo_ff[l] <= dividend[l];
            rem_ff[l] <= '0;
         end
      end else if (busy_ff) begin
         for (int l = 0; l < LANES; l++) begin
            quo_ff[l] <= quo_in[l];
            rem_ff[l] <= rem_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quotient[l]    = quo_ff[l];
         rem_nonzero[l] = (rem_ff[l] != '0);
      end
   end

   assign done = done_ff;

endmodule

>>> hw/rtl/tfs_datapath.sv
// ----------------------------------------------------------------------------
// Texture filter sampler datapath
// Texel stores, size registers, coordinate and weight arithmetic, channel
// accumulators and the result register, stepped by the controller.
// ----------------------------------------------------------------------------
module tfs_datapath #(
   parameter int MAX_SIDE = 64,
   parameter int MAX_TAPS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tfs_pkg::dp_cmd_type               cmd,
   output tfs_pkg::dp_status_type            status,
   input  logic                              csr_write,
   input  logic [tfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tfs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_level,
   input  logic [tfs_pkg::POS_W-1:0]         req_texel_col,
   input  logic [tfs_pkg::POS_W-1:0]         req_texel_row,
   input  logic [tfs_pkg::RGBA_W-1:0]        req_texel_rgba,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_u_coord,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_v_coord,
   input  logic [tfs_pkg::BLEND_W-1:0]       req_mip_blend,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_du_dx,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_dv_dx,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_du_dy,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_dv_dy,
   output logic [tfs_pkg::RGBA_W-1:0]        rsp_sample_rgba
);

   localparam int CDW  = tfs_pkg::COORD_W;
   localparam int SW   = $clog2(MAX_SIDE + 1);
   localparam int IW   = $clog2(MAX_SIDE);
   localparam int AW   = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int NW   = $clog2(MAX_TAPS + 1);
   localparam int OW   = NW + 2;
   localparam int PW   = OW + CDW;
   localparam int VW   = NW + 1;
   localparam int CW   = 21;
   localparam int XW   = CW + SW + 1;
   localparam int XIW  = XW - 16;
   localparam int SQW  = 2 * CDW - 1;
   localparam int LW   = SQW + 1;
   localparam int WTW  = 17;
   localparam int ACW  = 25;
   localparam int TSW  = 8 + NW;
   localparam int PRW  = tfs_pkg::POS_W + SW;
   localparam int RBW  = IW + SW;
   localparam int BLW  = 17;

   // Size registers.
   logic [tfs_pkg::CSR_DATA_W-1:0] base_width_ff, base_height_ff;
   logic [tfs_pkg::CSR_DATA_W-1:0] next_width_ff, next_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff  <= 7'd1;
         base_height_ff <= 7'd1;
         next_width_ff  <= 7'd1;
         next_height_ff <= 7'd1;
      end else if (csr_write) begin
         case (csr_index)
            tfs_pkg::CSR_BASE_WIDTH:  base_width_ff  <= csr_wdata;
            tfs_pkg::CSR_BASE_HEIGHT: base_height_ff <= csr_wdata;
            tfs_pkg::CSR_NEXT_WIDTH:  next_width_ff  <= csr_wdata;
            tfs_pkg::CSR_NEXT_HEIGHT: next_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [SW-1:0] sat_side(input logic [tfs_pkg::CSR_DATA_W-1:0] r);
      if (r == '0) begin
         return SW'(1);
      end else if (32'(r) > MAX_SIDE) begin
         return SW'(MAX_SIDE);
      end else begin
         return SW'(r);
      end
   endfunction

   function automatic logic [IW-1:0] clamp_idx(input logic signed [XIW:0] val,
                                               input logic [SW-1:0] sz);
      logic signed [XIW:0] hi;
      hi = $signed((XIW+1)'(sz)) - (XIW+1)'(1);
      if (val < 0) begin
         return '0;
      end else if (val > hi) begin
         return IW'(sz - SW'(1));
      end else begin
         return IW'(val);
      end
   endfunction

   logic [SW-1:0] bw, bh, nw, nh;
   assign bw = sat_side(base_width_ff);
   assign bh = sat_side(base_height_ff);
   assign nw = sat_side(next_width_ff);
   assign nh = sat_side(next_height_ff);

   // Captured request.
   logic                      lvl_ff;
   logic [tfs_pkg::POS_W-1:0] col_ff, row_ff;
   logic [tfs_pkg::RGBA_W-1:0] rgba_ff;
   logic signed [CDW-1:0]     u_ff, v_ff, dux_ff, dvx_ff, duy_ff, dvy_ff;
   logic [tfs_pkg::BLEND_W-1:0] blend_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == tfs_pkg::OP_LOAD) begin
         lvl_ff   <= req_level;
         col_ff   <= req_texel_col;
         row_ff   <= req_texel_row;
         rgba_ff  <= req_texel_rgba;
         u_ff     <= req_u_coord;
         v_ff     <= req_v_coord;
         blend_ff <= req_mip_blend;
         dux_ff   <= req_du_dx;
         dvx_ff   <= req_dv_dx;
         duy_ff   <= req_du_dy;
         dvy_ff   <= req_dv_dy;
      end
   end

   // Texel write.
   logic [SW-1:0]  req_w, req_h;
   logic [PRW-1:0] wr_prod;
   logic [AW-1:0]  wr_addr;
   logic           mem_we;

   assign req_w   = lvl_ff ? nw : bw;
   assign req_h   = lvl_ff ? nh : bh;
   assign wr_prod = PRW'(row_ff) * PRW'(req_w);
   assign wr_addr = AW'(wr_prod + PRW'(col_ff));
   assign mem_we  = (cmd.op == tfs_pkg::OP_WRITE) && (32'(col_ff) < 32'(req_w))
                    && (32'(row_ff) < 32'(req_h));

   // Tap count.
   logic [SQW-1:0] sq_ff [4];
   logic signed [2*CDW-1:0] sq_p [4];
   logic [LW-1:0]  lx, ly, lm;
   logic [NW-1:0]  n_ff, n_in, tap_ff;

   always_comb begin
      sq_p[0] = dux_ff * dux_ff;
      sq_p[1] = dvx_ff * dvx_ff;
      sq_p[2] = duy_ff * duy_ff;
      sq_p[3] = dvy_ff * dvy_ff;
   end

   assign lx = LW'(sq_ff[0]) + LW'(sq_ff[1]);
   assign ly = LW'(sq_ff[2]) + LW'(sq_ff[3]);
   assign lm = (lx > ly) ? lx : ly;

   always_comb begin
      n_in = NW'(1);
      for (int k = 2; k <= MAX_TAPS; k++) begin
         if (32'(k * k) <= 32'(lm[LW-1:26])) begin
            n_in = NW'(k);
         end
      end
   end

   // Tap offsets and the shared divider.
   logic signed [OW-1:0] off;
   logic signed [PW-1:0] px_ff, py_ff;
   logic [3:0][PW-1:0]   div_dividend;
   logic [VW-1:0]        div_divisor;
   logic [3:0][PW-1:0]   div_quo;
   logic [3:0]           div_nz;
   logic                 div_done;
   logic                 div_start;
   logic [TSW-1:0]       tsum_ff [4];

   assign off = $signed({1'b0, tap_ff, 1'b1}) - $signed({2'b0, n_ff});

   assign div_start = (cmd.op == tfs_pkg::OP_DIV_TAP) || (cmd.op == tfs_pkg::OP_DIV_AVG);

   always_comb begin
      if (cmd.op == tfs_pkg::OP_DIV_AVG) begin
         div_divisor = VW'(n_ff);
         for (int c = 0; c < 4; c++) begin
            div_dividend[c] = PW'(tsum_ff[c]) + PW'(n_ff >> 1);
         end
      end else begin
         div_divisor     = {n_ff, 1'b0};
         div_dividend[0] = px_ff[PW-1] ? PW'(-px_ff) : PW'(px_ff);
         div_dividend[1] = py_ff[PW-1] ? PW'(-py_ff) : PW'(py_ff);
         div_dividend[2] = '0;
         div_dividend[3] = '0;
      end
   end

   tfs_div #(
      .LANES(4),
      .DW   (PW),
      .VW   (VW)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .quotient   (div_quo),
      .rem_nonzero(div_nz),
      .done       (div_done)
   );

   logic signed [PW-1:0] qx, qy;
   assign qx = px_ff[PW-1] ? -$signed(div_quo[0] + PW'(div_nz[0])) : $signed(div_quo[0]);
   assign qy = py_ff[PW-1] ? -$signed(div_quo[1] + PW'(div_nz[1])) : $signed(div_quo[1]);

   // Bilinear tap.
   logic signed [CW-1:0] su_ff, sv_ff;
   logic                 tap_lvl_ff;
   logic [SW-1:0]        tw, th;
   logic signed [SW:0]   tw_s, th_s;
   logic signed [XW-1:0] xf_ff, yf_ff;
   logic signed [XIW:0]  x0_s, y0_s;
   logic [IW-1:0]        x0_ff, x1_ff, y0_ff, y1_ff;
   logic [7:0]           fx_ff, fy_ff;
   logic [8:0]           fxc, fyc;
   logic [WTW-1:0]       wt_ff [4];
   logic [AW-1:0]        rb0_ff, rb1_ff;
   logic [AW-1:0]        rd_addr;
   logic [ACW-1:0]       acc_ff [4];
   logic [tfs_pkg::RGBA_W-1:0] rd_data, base_rd_ff, next_rd_ff;
   logic [tfs_pkg::RGBA_W-1:0] tap_rgba, c0_ff, c1_ff, res_ff, rsp_ff;
   logic [tfs_pkg::RGBA_W-1:0] blend_rgba, avg_rgba;
   logic [tfs_pkg::RGBA_W-1:0] base_mem [DEPTH];
   logic [tfs_pkg::RGBA_W-1:0] next_mem [DEPTH];
   logic [8:0]           lw;

   assign tw   = tap_lvl_ff ? nw : bw;
   assign th   = tap_lvl_ff ? nh : bh;
   assign tw_s = $signed({1'b0, tw});
   assign th_s = $signed({1'b0, th});
   assign x0_s = $signed({xf_ff[XW-1], xf_ff[XW-1:16]});
   assign y0_s = $signed({yf_ff[XW-1], yf_ff[XW-1:16]});
   assign fxc  = 9'd256 - {1'b0, fx_ff};
   assign fyc  = 9'd256 - {1'b0, fy_ff};

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    rd_addr = rb0_ff + AW'(x0_ff);
         2'd1:    rd_addr = rb0_ff + AW'(x1_ff);
         2'd2:    rd_addr = rb1_ff + AW'(x0_ff);
         default: rd_addr = rb1_ff + AW'(x1_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we && !lvl_ff) begin
         base_mem[wr_addr] <= rgba_ff;
      end
      if (cmd.rd_en) begin
         base_rd_ff <= base_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && lvl_ff) begin
         next_mem[wr_addr] <= rgba_ff;
      end
      if (cmd.rd_en) begin
         next_rd_ff <= next_mem[rd_addr];
      end
   end

   assign rd_data = tap_lvl_ff ? next_rd_ff : base_rd_ff;

   always_comb begin
      logic [ACW-1:0] rnd;
      logic [BLW-1:0] bsum;
      lw = (blend_ff > 17'd65536) ? 9'd256 : blend_ff[16:8];
      for (int c = 0; c < 4; c++) begin
         rnd = acc_ff[c] + ACW'(32768);
         tap_rgba[c*8 +: 8] = rnd[23:16];
         bsum = BLW'(c0_ff[c*8 +: 8]) * BLW'(9'd256 - lw) + BLW'(c1_ff[c*8 +: 8]) * BLW'(lw)
                + BLW'(128);
         blend_rgba[c*8 +: 8] = bsum[15:8];
         avg_rgba[c*8 +: 8]   = div_quo[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
         n_ff   <= NW'(1);
      end else begin
         case (cmd.op)
            tfs_pkg::OP_COUNT: begin
               n_ff   <= n_in;
               tap_ff <= '0;
            end
            tfs_pkg::OP_TAP_END: tap_ff <= tap_ff + NW'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         tfs_pkg::OP_LOAD: begin
            for (int c = 0; c < 4; c++) begin
               tsum_ff[c] <= '0;
            end
         end
         tfs_pkg::OP_SQUARE: begin
            for (int s = 0; s < 4; s++) begin
               sq_ff[s] <= sq_p[s][SQW-1:0];
            end
         end
         tfs_pkg::OP_OFFSET: begin
            px_ff <= off * dux_ff;
            py_ff <= off * dvx_ff;
         end
         tfs_pkg::OP_TAP_POS: begin
            su_ff      <= CW'(u_ff) + CW'(qx);
            sv_ff      <= CW'(v_ff) + CW'(qy);
            tap_lvl_ff <= lvl_ff;
         end
         tfs_pkg::OP_CENTER: begin
            su_ff      <= CW'(u_ff);
            sv_ff      <= CW'(v_ff);
            tap_lvl_ff <= cmd.lvl_force ? cmd.lvl_val : lvl_ff;
         end
         tfs_pkg::OP_XF: begin
            xf_ff <= XW'(su_ff) * XW'(tw_s) - XW'(32768);
            yf_ff <= XW'(sv_ff) * XW'(th_s) - XW'(32768);
         end
         tfs_pkg::OP_IDX: begin
            x0_ff <= clamp_idx(x0_s, tw);
            x1_ff <= clamp_idx(x0_s + (XIW+1)'(1), tw);
            y0_ff <= clamp_idx(y0_s, th);
            y1_ff <= clamp_idx(y0_s + (XIW+1)'(1), th);
            fx_ff <= xf_ff[15:8];
            fy_ff <= yf_ff[15:8];
         end
         tfs_pkg::OP_WGT: begin
            wt_ff[0] <= WTW'(fxc) * WTW'(fyc);
            wt_ff[1] <= WTW'(fx_ff) * WTW'(fyc);
            wt_ff[2] <= WTW'(fxc) * WTW'(fy_ff);
            wt_ff[3] <= WTW'(fx_ff) * WTW'(fy_ff);
            rb0_ff   <= AW'(RBW'(y0_ff) * RBW'(tw));
            rb1_ff   <= AW'(RBW'(y1_ff) * RBW'(tw));
            for (int c = 0; c < 4; c++) begin
               acc_ff[c] <= '0;
            end
         end
         tfs_pkg::OP_TAP_END: begin
            c0_ff  <= c1_ff;
            c1_ff  <= tap_rgba;
            res_ff <= tap_rgba;
            for (int c = 0; c < 4; c++) begin
               tsum_ff[c] <= tsum_ff[c] + TSW'(tap_rgba[c*8 +: 8]);
            end
         end
         tfs_pkg::OP_BLEND:   res_ff <= blend_rgba;
         tfs_pkg::OP_AVG_END: res_ff <= avg_rgba;
         default: ;
      endcase
      if (cmd.acc_en) begin
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= acc_ff[c] + ACW'(rd_data[c*8 +: 8]) * ACW'(wt_ff[cmd.acc_sel]);
         end
      end
      if (cmd.out_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.last_tap = (tap_ff == n_ff - NW'(1));
   assign rsp_sample_rgba = rsp_ff;

endmodule

>>> hw/rtl/tfs_ctrl.sv
// ----------------------------------------------------------------------------
// Texture filter sampler controller
// Sequences writes, bilinear taps, trilinear blends and anisotropic tap loops,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module tfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_type,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tfs_pkg::dp_cmd_type    cmd,
   input  tfs_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_WRITE,
      S_SQUARE,
      S_COUNT,
      S_OFFSET,
      S_DIV_TAP,
      S_DIV_TAP_WAIT,
      S_TAP_POS,
      S_CENTER,
      S_XF,
      S_IDX,
      S_WGT,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_ACC3,
      S_TAP_END,
      S_BLEND,
      S_DIV_AVG,
      S_DIV_AVG_WAIT,
      S_AVG_END,
      S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] type_ff;
   logic       pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign accept = (state_ff == S_IDLE) && req_valid;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = tfs_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op  = tfs_pkg::OP_LOAD;
               pass_in = 1'b0;
               case (req_type)
                  tfs_pkg::REQ_WRITE: state_in = S_WRITE;
                  tfs_pkg::REQ_ANISO: state_in = S_SQUARE;
                  default:            state_in = S_CENTER;
               endcase
            end
         end
         S_WRITE: begin
            cmd.op   = tfs_pkg::OP_WRITE;
            state_in = S_IDLE;
         end
         S_SQUARE: begin
            cmd.op   = tfs_pkg::OP_SQUARE;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            cmd.op   = tfs_pkg::OP_COUNT;
            state_in = S_OFFSET;
         end
         S_OFFSET: begin
            cmd.op   = tfs_pkg::OP_OFFSET;
            state_in = S_DIV_TAP;
         end
         S_DIV_TAP: begin
            cmd.op   = tfs_pkg::OP_DIV_TAP;
            state_in = S_DIV_TAP_WAIT;
         end
         S_DIV_TAP_WAIT: begin
            if (status.div_done) begin
               state_in = S_TAP_POS;
            end
         end
         S_TAP_POS: begin
            cmd.op   = tfs_pkg::OP_TAP_POS;
            state_in = S_XF;
         end
         S_CENTER: begin
            cmd.op        = tfs_pkg::OP_CENTER;
            cmd.lvl_force = (type_ff == tfs_pkg::REQ_TRILINEAR);
            cmd.lvl_val   = pass_ff;
            state_in      = S_XF;
         end
         S_XF: begin
            cmd.op   = tfs_pkg::OP_XF;
            state_in = S_IDX;
         end
         S_IDX: begin
            cmd.op   = tfs_pkg::OP_IDX;
            state_in = S_WGT;
         end
         S_WGT: begin
            cmd.op   = tfs_pkg::OP_WGT;
            state_in = S_RD0;
         end
         S_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = 2'd0;
            state_in   = S_RD1;
         end
         S_RD1: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd1;
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = 2'd0;
            state_in    = S_RD2;
         end
         S_RD2: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd2;
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = 2'd1;
            state_in    = S_RD3;
         end
         S_RD3: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = 2'd3;
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = 2'd2;
            state_in    = S_ACC3;
         end
         S_ACC3: begin
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = 2'd3;
            state_in    = S_TAP_END;
         end
         S_TAP_END: begin
            cmd.op = tfs_pkg::OP_TAP_END;
            case (type_ff)
               tfs_pkg::REQ_TRILINEAR: begin
                  if (pass_ff) begin
                     state_in = S_BLEND;
                  end else begin
                     pass_in  = 1'b1;
                     state_in = S_CENTER;
                  end
               end
               tfs_pkg::REQ_ANISO: begin
                  state_in = status.last_tap ? S_DIV_AVG : S_OFFSET;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_BLEND: begin
            cmd.op   = tfs_pkg::OP_BLEND;
            state_in = S_OUT;
         end
         S_DIV_AVG: begin
            cmd.op   = tfs_pkg::OP_DIV_AVG;
            state_in = S_DIV_AVG_WAIT;
         end
         S_DIV_AVG_WAIT: begin
            if (status.div_done) begin
               state_in = S_AVG_END;
            end
         end
         S_AVG_END: begin
            cmd.op   = tfs_pkg::OP_AVG_END;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         type_ff      <= tfs_pkg::REQ_WRITE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            type_ff <= req_type;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/texture_filter_sampler_unit.sv
// ----------------------------------------------------------------------------
// Texture filter sampler unit
// Two-level RGBA8 texture store with bilinear, trilinear and anisotropic
// filtering in fixed point.
// ----------------------------------------------------------------------------
// One request is worked at a time. A texel write passes through the write
// state before the next request is taken. A bilinear sample makes four reads
// from the texel store of its level, which has one read port; a trilinear
// sample makes four in each level and blends the two taps. An anisotropic
// sample runs the serial divider once to place each tap and once more to
// average the taps; the divider is clog2(MAX_TAPS+1) + 21 bits wide (25 at the
// default sizes). A finished result waits in the output register while the
// next request is already accepted. Texel stores need no clearing after reset.
module texture_filter_sampler_unit #(
   parameter int MAX_SIDE = 64,
   parameter int MAX_TAPS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [tfs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic                               req_level,
   input  logic [tfs_pkg::POS_W-1:0]          req_texel_col,
   input  logic [tfs_pkg::POS_W-1:0]          req_texel_row,
   input  logic [tfs_pkg::RGBA_W-1:0]         req_texel_rgba,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_u_coord,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_v_coord,
   input  logic [tfs_pkg::BLEND_W-1:0]        req_mip_blend,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_du_dx,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_dv_dx,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_du_dy,
   input  logic signed [tfs_pkg::COORD_W-1:0] req_dv_dy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tfs_pkg::RGBA_W-1:0]         rsp_sample_rgba
);

   tfs_pkg::dp_cmd_type    cmd;
   tfs_pkg::dp_status_type status;

   tfs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_type (req_type),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   tfs_datapath #(
      .MAX_SIDE(MAX_SIDE),
      .MAX_TAPS(MAX_TAPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_level      (req_level),
      .req_texel_col  (req_texel_col),
      .req_texel_row  (req_texel_row),
      .req_texel_rgba (req_texel_rgba),
      .req_u_coord    (req_u_coord),
      .req_v_coord    (req_v_coord),
      .req_mip_blend  (req_mip_blend),
      .req_du_dx      (req_du_dx),
      .req_dv_dx      (req_dv_dx),
      .req_du_dy      (req_du_dy),
      .req_dv_dy      (req_dv_dy),
      .rsp_sample_rgba(rsp_sample_rgba)
   );

   // A transfer always starts work, so the request side stalls right after it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not stalled after a transfer");

   // A texel write produces no result and frees the unit after its write state.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == tfs_pkg::REQ_WRITE |=> ##1 !req_stall)
      else $error("texel write did not finish in two cycles");

   // A new result only appears at the end of a sample in progress.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a sample in progress");

endmodule
